@@ hdl/dhs_pkg.sv @@
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared types and constants for the drift health scorer: register indexes,
// configuration record, divider handshake records and sequencer states.
// ----------------------------------------------------------------------------
package dhs_pkg;

  localparam int JITTER_W    = 16;
  localparam int WEIGHT_W    = 9;
  localparam int SCORE_W     = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int NUMER_W     = 24;
  localparam int DIVISOR_W   = 16;
  localparam int CAT_W       = 3;

  localparam logic [SCORE_W-1:0] SCORE_MAX  = 8'd255;
  localparam logic [SCORE_W+1:0] TREND_BAND = 10'd2;

  localparam logic signed [1:0] TREND_UP   = 2'sd1;
  localparam logic signed [1:0] TREND_DOWN = -2'sd1;
  localparam logic signed [1:0] TREND_FLAT = 2'sd0;

  localparam logic [CAT_W-1:0] CAT_BEARING = 3'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASELINE_JITTER   = 8'd0,
    REG_WEIGHT_BEARING    = 8'd1,
    REG_WEIGHT_BALANCE    = 8'd2,
    REG_WEIGHT_CONNECTION = 8'd3,
    REG_WEIGHT_THERMAL    = 8'd4,
    REG_WEIGHT_ELECTRICAL = 8'd5,
    REG_DEGRADED_LEVEL    = 8'd6,
    REG_CRITICAL_LEVEL    = 8'd7
  } reg_index_t;

  typedef struct packed {
    logic [JITTER_W-1:0] baseline_jitter;
    logic [WEIGHT_W-1:0] weight_bearing;
    logic [WEIGHT_W-1:0] weight_balance;
    logic [WEIGHT_W-1:0] weight_connection;
    logic [WEIGHT_W-1:0] weight_thermal;
    logic [WEIGHT_W-1:0] weight_electrical;
    logic [SCORE_W-1:0]  degraded_level;
    logic [SCORE_W-1:0]  critical_level;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [NUMER_W-1:0]   numer;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [NUMER_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FINISH
  } state_t;

endpackage

@@ hdl/dhs_cfg.sv @@
// ----------------------------------------------------------------------------
// dhs_cfg
// Configuration register file. Writes to indexes outside the register list
// are dropped.
// ----------------------------------------------------------------------------
module dhs_cfg
  import dhs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline_jitter   <= '0;
      cfg.weight_bearing    <= 9'd64;
      cfg.weight_balance    <= 9'd48;
      cfg.weight_connection <= 9'd48;
      cfg.weight_thermal    <= 9'd48;
      cfg.weight_electrical <= 9'd48;
      cfg.degraded_level    <= 8'd128;
      cfg.critical_level    <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASELINE_JITTER:   cfg.baseline_jitter   <= cfg_data[JITTER_W-1:0];
        REG_WEIGHT_BEARING:    cfg.weight_bearing    <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_BALANCE:    cfg.weight_balance    <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_CONNECTION: cfg.weight_connection <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_THERMAL:    cfg.weight_thermal    <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_ELECTRICAL: cfg.weight_electrical <= cfg_data[WEIGHT_W-1:0];
        REG_DEGRADED_LEVEL:    cfg.degraded_level    <= cfg_data[SCORE_W-1:0];
        REG_CRITICAL_LEVEL:    cfg.critical_level    <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/dhs_divider.sv @@
// ----------------------------------------------------------------------------
// dhs_divider
// Restoring divider, one quotient bit per cycle, 24-bit numerator over a
// 16-bit divisor. The quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module dhs_divider
  import dhs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUMER_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUMER_W - 1);

  logic [NUMER_W-1:0]   num;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] rem;
  logic [CNT_W-1:0]     count;
  logic                 busy;
  logic                 done;

  logic [DIVISOR_W:0]   rem_shift;
  logic                 fits;
  logic [DIVISOR_W:0]   rem_diff;

  assign rem_shift = {rem, num[NUMER_W-1]};
  assign fits      = rem_shift >= {1'b0, divisor};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The numerator register shifts out dividend bits and shifts in quotient bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num     <= req.numer;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      num <= {num[NUMER_W-2:0], fits};
      rem <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = num;

endmodule

@@ hdl/drift_health_scorer.sv @@
// ----------------------------------------------------------------------------
// drift_health_scorer
// Bearing health scoring from jitter drift, with weighted composite, trend,
// threshold flags and worst sub-score.
// ----------------------------------------------------------------------------
// One item is worked at a time. When the baseline is nonzero and the jitter
// is above it, the drift ratio goes through a bit-serial restoring divider
// (state ST_DIV); otherwise the item goes straight from ST_IDLE to ST_MUL.
// After the bearing score is known, state ST_MUL registers the weighted
// product and state ST_FINISH adds up the composite and loads the output
// register. The input stays stalled while an item is in work; a finished
// result waits in the output register, and the block holds its last step
// until that register is free.
module drift_health_scorer
  import dhs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [JITTER_W-1:0]    jitter_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SCORE_W-1:0]     bearing_score,
  output logic [SCORE_W-1:0]     composite_health,
  output logic signed [1:0]      trend,
  output logic                   degraded,
  output logic                   critical,
  output logic [SCORE_W-1:0]     worst_score,
  output logic [CAT_W-1:0]       worst_category,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t state;
  state_t state_next;

  logic [SCORE_W-1:0]          bearing_held;
  logic [SCORE_W-1:0]          composite_held;
  logic [SCORE_W+WEIGHT_W-1:0] prod;

  logic accept;
  logic need_div;
  logic out_load;
  logic div_start;

  logic [JITTER_W-1:0]   drift;
  logic [WEIGHT_W+1:0]   rest_weights;
  logic [WEIGHT_W+9:0]   rest_sum;
  logic [15:0]           total;
  logic [SCORE_W-1:0]    composite_new;
  logic signed [1:0]     trend_new;

  dhs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dhs_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign need_div = (cfg.baseline_jitter != '0) && (jitter_sample > cfg.baseline_jitter);
  assign drift    = jitter_sample - cfg.baseline_jitter;

  // drift * 255 as (drift << 8) - drift.
  assign div_req.start   = div_start;
  assign div_req.numer   = {drift, 8'd0} - {8'd0, drift};
  assign div_req.divisor = cfg.baseline_jitter;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = need_div ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        accept    = in_valid;
        div_start = in_valid && need_div;
      end
      ST_FINISH: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // The four fixed sub-scores contribute 255 times the sum of their weights.
  assign rest_weights = {2'b0, cfg.weight_balance} + {2'b0, cfg.weight_connection}
                      + {2'b0, cfg.weight_thermal} + {2'b0, cfg.weight_electrical};
  assign rest_sum     = {rest_weights, 8'd0} - {8'd0, rest_weights};
  assign total        = prod[15:0] + rest_sum[15:0];
  assign composite_new = total[15:8];

  always_comb begin
    trend_new = TREND_FLAT;
    if ({2'b0, composite_new} > {2'b0, composite_held} + TREND_BAND) begin
      trend_new = TREND_UP;
    end else if ({2'b0, composite_new} + TREND_BAND < {2'b0, composite_held}) begin
      trend_new = TREND_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bearing_held   <= SCORE_MAX;
      composite_held <= SCORE_MAX;
      out_valid      <= 1'b0;
    end else begin
      // A zero baseline leaves the bearing score where it was.
      if (accept && !need_div && (cfg.baseline_jitter != '0)) begin
        bearing_held <= SCORE_MAX;
      end else if (state == ST_DIV && div_rsp.done) begin
        if (div_rsp.quot >= NUMER_W'(SCORE_MAX)) bearing_held <= '0;
        else bearing_held <= SCORE_MAX - div_rsp.quot[SCORE_W-1:0];
      end
      if (out_load) begin
        composite_held <= composite_new;
        out_valid      <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The other sub-scores are all at full scale, so the bearing score is
  // always the worst one and alone decides the flags.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) prod <= bearing_held * cfg.weight_bearing;
    if (out_load) begin
      bearing_score    <= bearing_held;
      composite_health <= composite_new;
      trend            <= trend_new;
      degraded         <= bearing_held < cfg.degraded_level;
      critical         <= bearing_held < cfg.critical_level;
      worst_score      <= bearing_held;
      worst_category   <= CAT_BEARING;
    end
  end

endmodule
